// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the stepper driver modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and coil tables for the half-step stepper driver.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int SAMPLE_BITS_DEF      = 12;
    localparam int SAMPLE_SHIFT_DIV_DEF = 64;

    localparam int BASE_W  = 16;   // base registers and step counter
    localparam int LEVEL_W = 12;   // LED levels
    localparam int RAD_W   = 17;   // base + scaled sample
    localparam int ROOT_W  = 9;    // floor(sqrt(2^17 - 1)) fits
    localparam int DELAY_W = 9;
    localparam int COIL_W  = 4;
    localparam int MODE_W  = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PASS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_OFF    = 3'd4;

    localparam logic [BASE_W-1:0]  PAUSE_BASE_RST = 16'd500;
    localparam logic [BASE_W-1:0]  STEP_BASE_RST  = 16'd1;
    localparam logic [BASE_W-1:0]  STEPS_PASS_RST = 16'd4096;
    localparam logic [LEVEL_W-1:0] LED_ON_RST     = 12'd2430;
    localparam logic [LEVEL_W-1:0] LED_OFF_RST    = 12'd1181;

    typedef logic [COIL_W-1:0] coil_t;

    function automatic coil_t cw_coil(input logic [2:0] idx);
        coil_t c;
        case (idx)
            3'd0:    c = 4'd9;
            3'd1:    c = 4'd8;
            3'd2:    c = 4'd12;
            3'd3:    c = 4'd4;
            3'd4:    c = 4'd6;
            3'd5:    c = 4'd2;
            3'd6:    c = 4'd3;
            default: c = 4'd1;
        endcase
        return c;
    endfunction

    function automatic coil_t ccw_coil(input logic [2:0] idx);
        coil_t c;
        case (idx)
            3'd0:    c = 4'd12;
            3'd1:    c = 4'd8;
            3'd2:    c = 4'd9;
            3'd3:    c = 4'd1;
            3'd4:    c = 4'd3;
            3'd5:    c = 4'd2;
            3'd6:    c = 4'd6;
            default: c = 4'd4;
        endcase
        return c;
    endfunction

endpackage

// ===== design/shs_tick_if.sv =====
// ----------------------------------------------------------------------------
// shs_tick_if
// Tick channel: one converter reading per timer tick.
// ----------------------------------------------------------------------------
interface shs_tick_if #(
    parameter int SAMPLE_BITS = shs_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

// ===== design/shs_result_if.sv =====
// ----------------------------------------------------------------------------
// shs_result_if
// Result channel: coil drive and status per tick.
// ----------------------------------------------------------------------------
interface shs_result_if;
    logic                      valid;
    logic                      ready;
    logic [shs_pkg::COIL_W-1:0] coil_pattern;
    logic                      led_on;
    logic                      moving_ccw;
    logic                      step_taken;
    logic                      pass_done;

    modport source (output valid, output coil_pattern, output led_on, output moving_ccw,
                    output step_taken, output pass_done, input ready);
    modport sink   (input valid, input coil_pattern, input led_on, input moving_ccw,
                    input step_taken, input pass_done, output ready);
endinterface

// ===== design/shs_isqrt.sv =====
// ----------------------------------------------------------------------------
// shs_isqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shs_isqrt #(
    parameter int RAD_W  = shs_pkg::RAD_W,
    parameter int ROOT_W = shs_pkg::ROOT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);
    localparam int PAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    // next two radicand bits enter the partial remainder
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[PAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = PAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[PAD_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    `SHS_ASSERT_NOW(a_cnt_range, busy_reg, cnt_reg <= LAST)
    `SHS_ASSERT_NEXT(a_start_busy, start, busy_reg)
    `SHS_ASSERT_NEXT(a_done_after_last, busy_reg && !start && cnt_reg == LAST, done_reg)

endmodule

// ===== design/stepper_half_step_speed_by_adc_core.sv =====
// ----------------------------------------------------------------------------
// stepper_half_step_speed_by_adc_core
// Half-step stepper sequencer; delay length set by the converter reading.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  tick     | in  | valid/ready        | adc_sample
//  result   | out | valid/ready        | coil_pattern, led_on, moving_ccw,
//           |     |                    | step_taken, pass_done
//  cfg      | in  | cfg_wr_en (no ack) | cfg_index, cfg_data
//
//  A tick that continues a delay goes from S_IDLE to S_FIN, where the result
//  register is loaded once it is free; ready returns with S_IDLE. A tick that
//  starts a delay runs the bit-serial root in S_ROOT, one root bit per cycle,
//  and then loads the result register from S_FIN.
//  Reset (rst_n low, async) clears mode, counters, coils and LED; config
//  registers return to their defaults. A new tick is taken only from idle;
//  a result held by a stalled sink blocks the next completion, not accept.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_half_step_speed_by_adc_core #(
    parameter int SAMPLE_BITS      = shs_pkg::SAMPLE_BITS_DEF,
    parameter int SAMPLE_SHIFT_DIV = shs_pkg::SAMPLE_SHIFT_DIV_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [shs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [shs_pkg::CFG_DATA_W-1:0]   cfg_data,
    shs_tick_if.sink                         tick,
    shs_result_if.source                     result
);
    localparam int BASE_W  = shs_pkg::BASE_W;
    localparam int LEVEL_W = shs_pkg::LEVEL_W;
    localparam int RAD_W   = shs_pkg::RAD_W;
    localparam int ROOT_W  = shs_pkg::ROOT_W;
    localparam int DELAY_W = shs_pkg::DELAY_W;
    localparam int MODE_W  = shs_pkg::MODE_W;
    // common width for the LED compares
    localparam int CMP_W   = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROOT = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // config registers
    logic [BASE_W-1:0]  pause_base_reg;
    logic [BASE_W-1:0]  step_base_reg;
    logic [BASE_W-1:0]  steps_pass_reg;
    logic [LEVEL_W-1:0] led_on_lvl_reg;
    logic [LEVEL_W-1:0] led_off_lvl_reg;

    // motion state
    logic [1:0]            state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [BASE_W-1:0]     steps_reg, steps_next;
    logic [DELAY_W-1:0]    delay_reg, delay_next;
    shs_pkg::coil_t        coil_reg, coil_next;
    logic                  led_reg, led_next;
    logic                  stepped_reg, stepped_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    shs_pkg::coil_t        out_coil_reg, out_coil_next;
    logic                  out_led_reg, out_led_next;
    logic                  out_ccw_reg, out_ccw_next;
    logic                  out_step_reg, out_step_next;
    logic                  out_done_reg, out_done_next;

    logic                  accept;
    logic                  in_pass;
    logic                  out_free;
    logic [CMP_W-1:0]      sample_cmp;
    logic [SAMPLE_BITS-1:0] sample_scaled;
    logic [BASE_W-1:0]     base_sel;
    logic [RAD_W-1:0]      radicand;
    logic                  root_start;
    logic                  root_done;
    logic [ROOT_W-1:0]     root;

    assign accept    = tick.valid && tick.ready;
    assign in_pass   = mode_reg[0];
    assign out_free  = !out_valid_reg || result.ready;
    assign tick.ready = (state_reg == S_IDLE);

    // scaled reading and the sum under the root
    assign sample_cmp    = CMP_W'(tick.adc_sample);
    assign sample_scaled = SAMPLE_BITS'(tick.adc_sample / SAMPLE_SHIFT_DIV);
    assign base_sel      = in_pass ? step_base_reg : pause_base_reg;
    assign radicand      = RAD_W'(base_sel) + RAD_W'(sample_scaled);
    assign root_start    = accept && (delay_reg == '0);

    shs_isqrt #(
        .RAD_W  (RAD_W),
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    // config writes (unknown index ignored)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_base_reg  <= shs_pkg::PAUSE_BASE_RST;
            step_base_reg   <= shs_pkg::STEP_BASE_RST;
            steps_pass_reg  <= shs_pkg::STEPS_PASS_RST;
            led_on_lvl_reg  <= shs_pkg::LED_ON_RST;
            led_off_lvl_reg <= shs_pkg::LED_OFF_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                shs_pkg::CFG_PAUSE_BASE: pause_base_reg  <= cfg_data[BASE_W-1:0];
                shs_pkg::CFG_STEP_BASE:  step_base_reg   <= cfg_data[BASE_W-1:0];
                shs_pkg::CFG_STEPS_PASS: steps_pass_reg  <= cfg_data[BASE_W-1:0];
                shs_pkg::CFG_LED_ON:     led_on_lvl_reg  <= cfg_data[LEVEL_W-1:0];
                shs_pkg::CFG_LED_OFF:    led_off_lvl_reg <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        steps_next     = steps_reg;
        delay_next     = delay_reg;
        coil_next      = coil_reg;
        led_next       = led_reg;
        stepped_next   = stepped_reg;
        out_valid_next = out_valid_reg;
        out_coil_next  = out_coil_reg;
        out_led_next   = out_led_reg;
        out_ccw_next   = out_ccw_reg;
        out_step_next  = out_step_reg;
        out_done_next  = out_done_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    stepped_next = 1'b0;
                    if (delay_reg == '0)
                    begin
                        // delay start: advance coils in a pass, sample LED
                        if (in_pass)
                        begin
                            coil_next    = mode_reg[1] ? shs_pkg::ccw_coil(steps_reg[2:0])
                                                       : shs_pkg::cw_coil(steps_reg[2:0]);
                            steps_next   = steps_reg + 1'b1;
                            stepped_next = 1'b1;
                        end
                        if (sample_cmp >= CMP_W'(led_on_lvl_reg))
                        begin
                            led_next = 1'b1;
                        end
                        else if (sample_cmp <= CMP_W'(led_off_lvl_reg))
                        begin
                            led_next = 1'b0;
                        end
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        delay_next = delay_reg - 1'b1;
                        state_next = S_FIN;
                    end
                end
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    // a zero root still gives a one-tick delay
                    delay_next = (root == '0) ? '0 : DELAY_W'(root - 1'b1);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_coil_next  = coil_reg;
                    out_led_next   = led_reg;
                    out_ccw_next   = mode_reg[1];
                    out_step_next  = stepped_reg;
                    out_done_next  = 1'b0;
                    if (delay_reg == '0)
                    begin
                        if (!in_pass)
                        begin
                            mode_next  = mode_reg + 1'b1;
                            steps_next = '0;
                        end
                        else if (steps_reg >= steps_pass_reg)
                        begin
                            out_done_next = 1'b1;
                            mode_next     = mode_reg + 1'b1;
                            steps_next    = '0;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= '0;
            steps_reg     <= '0;
            delay_reg     <= '0;
            coil_reg      <= '0;
            led_reg       <= 1'b0;
            stepped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            steps_reg     <= steps_next;
            delay_reg     <= delay_next;
            coil_reg      <= coil_next;
            led_reg       <= led_next;
            stepped_reg   <= stepped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_coil_reg <= out_coil_next;
        out_led_reg  <= out_led_next;
        out_ccw_reg  <= out_ccw_next;
        out_step_reg <= out_step_next;
        out_done_reg <= out_done_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.coil_pattern = out_coil_reg;
    assign result.led_on       = out_led_reg;
    assign result.moving_ccw   = out_ccw_reg;
    assign result.step_taken   = out_step_reg;
    assign result.pass_done    = out_done_reg;

    // a step always drives a nonzero table entry
    `SHS_ASSERT_NOW(a_step_coil, out_valid_reg && out_step_reg, out_coil_reg != '0)
    // the root only runs for a delay that starts on this tick
    `SHS_ASSERT_NOW(a_root_delay_zero, state_reg == S_ROOT, delay_reg == '0)
    // a delay start goes to the root unit
    `SHS_ASSERT_NEXT(a_start_root, root_start, state_reg == S_ROOT)
    // pass end only reported with a step count reset
    `SHS_ASSERT_NEXT(a_done_clears, state_reg == S_FIN && out_free && out_done_next,
                     steps_reg == '0)

endmodule
